/* rtl/sob_pkg.sv */
// ----------------------------------------------------------------------------
// sob_pkg
// Shared constants for the RGBA8 source-over blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package sob_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_OPACITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_W   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_H   = 3'd4;

  localparam int OP_W    = 17;
  localparam int SHIFT_W = 16;
  localparam int SIZE_W  = 15;
  localparam int DXW     = 18;

  localparam logic [OP_W-1:0] OPAQUE_Q16 = 17'd65536;

  localparam int S_W   = 24;
  localparam int OA_W  = 32;
  localparam int P_W   = 40;
  localparam int NUM_W = 41;
  localparam int DEN_W = 33;
  localparam int Q_W   = 9;

  localparam logic [S_W-1:0] FULL_D = 24'd16711680;

  localparam int N_COLOR = 3;
  localparam int N_LANE  = 4;

endpackage
`default_nettype wire

/* rtl/sob_if.sv */
// ----------------------------------------------------------------------------
// sob_in_if / sob_out_if
// Request and result channels of the source-over blend block.
// ----------------------------------------------------------------------------
`default_nettype none
interface sob_in_if #(parameter int COORD_BITS = 14);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] src_x;
  logic [COORD_BITS-1:0] src_y;
  logic [7:0]            src_red;
  logic [7:0]            src_green;
  logic [7:0]            src_blue;
  logic [7:0]            src_alpha;
  logic [7:0]            dst_red;
  logic [7:0]            dst_green;
  logic [7:0]            dst_blue;
  logic [7:0]            dst_alpha;
  modport source (output valid, src_x, src_y, src_red, src_green, src_blue, src_alpha,
                  dst_red, dst_green, dst_blue, dst_alpha, input ready);
  modport sink   (input valid, src_x, src_y, src_red, src_green, src_blue, src_alpha,
                  dst_red, dst_green, dst_blue, dst_alpha, output ready);
endinterface

interface sob_out_if #(parameter int COORD_BITS = 14);
  logic                  valid;
  logic                  ready;
  logic                  in_bounds;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic [7:0]            out_alpha;
  modport source (output valid, in_bounds, out_x, out_y, out_red, out_green, out_blue,
                  out_alpha, input ready);
  modport sink   (input valid, in_bounds, out_x, out_y, out_red, out_green, out_blue,
                  out_alpha, output ready);
endinterface
`default_nettype wire

/* rtl/sob_div.sv */
// ----------------------------------------------------------------------------
// sob_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module sob_div (
  input  wire logic                       clk,
  input  wire logic [sob_pkg::Q_W-1:0]    en,
  input  wire logic [sob_pkg::NUM_W-1:0]  n2,
  input  wire logic [sob_pkg::DEN_W-1:0]  d2,
  output logic      [sob_pkg::Q_W-1:0]    q
);
  import sob_pkg::*;

  logic [NUM_W-1:0] r_r [Q_W];
  logic [DEN_W-1:0] d_r [Q_W];
  logic [Q_W-1:0]   q_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [NUM_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [Q_W-1:0]   q_in;
    logic [NUM_W-1:0] ds;

    if (k == 0) begin : g_first
      assign r_in = n2;
      assign d_in = d2;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_r[k-1];
      assign d_in = d_r[k-1];
      assign q_in = q_r[k-1];
    end

    assign ds = NUM_W'(d_in) << (Q_W-1-k);

    always_ff @(posedge clk) begin
      if (en[k]) begin
        d_r[k] <= d_in;
        if (r_in >= ds) begin
          r_r[k] <= r_in - ds;
          q_r[k] <= q_in | (Q_W'(1) << (Q_W-1-k));
        end else begin
          r_r[k] <= r_in;
          q_r[k] <= q_in;
        end
      end
    end
  end

  assign q = q_r[Q_W-1];

endmodule
`default_nettype wire

/* rtl/rgba8_source_over_blend.sv */
// ----------------------------------------------------------------------------
// rgba8_source_over_blend
// Source-over compositing of straight-alpha RGBA8 with clipping and opacity.
// ----------------------------------------------------------------------------
// Accepts one request per cycle unless the result side stalls; each stage holds its item under stall.
// The 9-stage divider (one quotient bit per stage) sets the depth.
// Reset: synchronous active-low; clears all valid bits and resets the configuration registers
// (opacity to opaque, shifts and sizes to zero).
`default_nettype none
module rgba8_source_over_blend #(
  parameter int COORD_BITS = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sob_in_if.sink                             in_req,
  sob_out_if.source                          out_rsp,
  input  wire logic                          cfg_we,
  input  wire logic [sob_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [sob_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sob_pkg::*;

  localparam int NSTG = 4 + Q_W + 1;
  localparam int OUT_STG = NSTG - 1;
  localparam int LIM_W = COORD_BITS + 1;
  localparam int AN_W = DEN_W + 1;

  // configuration
  logic [OP_W-1:0]    op_r;
  logic [SHIFT_W-1:0] sx_r, sy_r;
  logic [SIZE_W-1:0]  dw_r, dh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OPAQUE_Q16;
      sx_r <= '0;
      sy_r <= '0;
      dw_r <= '0;
      dh_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OPACITY: op_r <= cfg_wdata;
        REG_SHIFT_X: sx_r <= cfg_wdata[SHIFT_W-1:0];
        REG_SHIFT_Y: sy_r <= cfg_wdata[SHIFT_W-1:0];
        REG_DEST_W:  dw_r <= cfg_wdata[SIZE_W-1:0];
        REG_DEST_H:  dh_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage control
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] go;

  always_comb begin
    go[NSTG-1] = !v_r[NSTG-1] || out_rsp.ready;
    for (int i = NSTG-2; i >= 0; i--) begin
      go[i] = !v_r[i] || go[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (go[i]) begin
          v_r[i] <= (i == 0) ? in_req.valid : v_r[i-1];
        end
      end
    end
  end

  assign in_req.ready = go[0];

  // stage 1: clip, scale source alpha
  logic signed [DXW-1:0] dx, dy;
  logic [LIM_W-1:0]      lim_w, lim_h;
  logic [OP_W-1:0]       op_sat;
  logic                  inb;
  logic [OP_W+7:0]       s_full;
  logic [7:0]            cs_in [N_COLOR];
  logic [7:0]            cd_in [N_COLOR];

  assign dx = signed'(DXW'({1'b0, in_req.src_x})) + DXW'(signed'(sx_r));
  assign dy = signed'(DXW'({1'b0, in_req.src_y})) + DXW'(signed'(sy_r));
  assign lim_w = (DXW'(dw_r) > DXW'(1 << COORD_BITS)) ? LIM_W'(1 << COORD_BITS)
                                                       : LIM_W'(dw_r);
  assign lim_h = (DXW'(dh_r) > DXW'(1 << COORD_BITS)) ? LIM_W'(1 << COORD_BITS)
                                                       : LIM_W'(dh_r);
  assign inb = !dx[DXW-1] && !dy[DXW-1] && (dx < signed'(DXW'(lim_w)))
            && (dy < signed'(DXW'(lim_h)));
  assign op_sat = (op_r > OPAQUE_Q16) ? OPAQUE_Q16 : op_r;
  assign s_full = in_req.src_alpha * op_sat;
  assign cs_in[0] = in_req.src_red;
  assign cs_in[1] = in_req.src_green;
  assign cs_in[2] = in_req.src_blue;
  assign cd_in[0] = in_req.dst_red;
  assign cd_in[1] = in_req.dst_green;
  assign cd_in[2] = in_req.dst_blue;

  logic                  inb1_r, inb2_r, inb3_r;
  logic [COORD_BITS-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r, x4_r, y4_r;
  logic [S_W-1:0]        s1_r, s2_r;
  logic [7:0]            cs1_r [N_COLOR];
  logic [7:0]            cd1_r [N_COLOR];
  logic [7:0]            ad1_r;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      inb1_r <= inb;
      x1_r   <= inb ? dx[COORD_BITS-1:0] : '0;
      y1_r   <= inb ? dy[COORD_BITS-1:0] : '0;
      s1_r   <= s_full[S_W-1:0];
      cs1_r  <= cs_in;
      cd1_r  <= cd_in;
      ad1_r  <= in_req.dst_alpha;
    end
  end

  // stage 2: inverse alpha and first products
  logic [S_W-1:0]  inv_c, inv2_r;
  logic [OA_W-1:0] a255s2_r, adinv2_r;
  logic [15:0]     cs255_2_r [N_COLOR];
  logic [15:0]     cdad2_r   [N_COLOR];

  assign inv_c = FULL_D - s1_r;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      inb2_r   <= inb1_r;
      x2_r     <= x1_r;
      y2_r     <= y1_r;
      s2_r     <= s1_r;
      inv2_r   <= inv_c;
      a255s2_r <= (OA_W'(s1_r) << 8) - OA_W'(s1_r);
      adinv2_r <= OA_W'(ad1_r) * OA_W'(inv_c);
      for (int l = 0; l < N_COLOR; l++) begin
        cs255_2_r[l] <= (16'(cs1_r[l]) << 8) - 16'(cs1_r[l]);
        cdad2_r[l]   <= cd1_r[l] * ad1_r;
      end
    end
  end

  // stage 3: output alpha and weighted channels
  logic [OA_W-1:0] oa3_r;
  logic [P_W-1:0]  p1_r [N_COLOR];
  logic [P_W-1:0]  p2_r [N_COLOR];

  always_ff @(posedge clk) begin
    if (go[2]) begin
      inb3_r <= inb2_r;
      x3_r   <= x2_r;
      y3_r   <= y2_r;
      oa3_r  <= a255s2_r + adinv2_r;
      for (int l = 0; l < N_COLOR; l++) begin
        p1_r[l] <= P_W'(cs255_2_r[l]) * P_W'(s2_r);
        p2_r[l] <= P_W'(cdad2_r[l]) * P_W'(inv2_r);
      end
    end
  end

  // stage 4: rounding numerators; alpha divides by 255 << 17 via reciprocal
  logic [NUM_W-1:0] n2_r [N_COLOR];
  logic [DEN_W-1:0] d2_r [N_COLOR];
  logic             zero4_r;
  logic             inb4_r;
  logic [Q_W-1:0]   a4_r;
  logic [AN_W-1:0]  an_c;
  logic [15:0]      am_c;
  logic [16:0]      as_c;

  assign an_c = {1'b0, oa3_r, 1'b0} + AN_W'(FULL_D);
  assign am_c = an_c[32:17];
  assign as_c = 17'(am_c) + 17'(am_c[15:8]) + 17'd1;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      x4_r    <= x3_r;
      y4_r    <= y3_r;
      inb4_r  <= inb3_r;
      zero4_r <= !inb3_r || (oa3_r == '0);
      a4_r    <= as_c[16:8];
      for (int l = 0; l < N_COLOR; l++) begin
        n2_r[l] <= ((NUM_W'(p1_r[l]) + NUM_W'(p2_r[l])) << 1) + NUM_W'(oa3_r);
        d2_r[l] <= {oa3_r, 1'b0};
      end
    end
  end

  // divider lanes
  logic [Q_W-1:0] q [N_LANE];

  for (genvar l = 0; l < N_COLOR; l++) begin : g_lane
    sob_div u_div (
      .clk (clk),
      .en  (go[4 +: Q_W]),
      .n2  (n2_r[l]),
      .d2  (d2_r[l]),
      .q   (q[l])
    );
  end

  logic [COORD_BITS-1:0] xd_r [Q_W];
  logic [COORD_BITS-1:0] yd_r [Q_W];
  logic                  zd_r [Q_W];
  logic                  bd_r [Q_W];
  logic [Q_W-1:0]        ad_r [Q_W];

  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_W; k++) begin
      if (go[4+k]) begin
        xd_r[k] <= (k == 0) ? x4_r : xd_r[k-1];
        yd_r[k] <= (k == 0) ? y4_r : yd_r[k-1];
        zd_r[k] <= (k == 0) ? zero4_r : zd_r[k-1];
        bd_r[k] <= (k == 0) ? inb4_r : bd_r[k-1];
        ad_r[k] <= (k == 0) ? a4_r : ad_r[k-1];
      end
    end
  end

  assign q[N_LANE-1] = ad_r[Q_W-1];

  // output register
  logic                  ob_r;
  logic [COORD_BITS-1:0] ox_r, oy_r;
  logic [7:0]            oc_r [N_LANE];

  always_ff @(posedge clk) begin
    if (go[OUT_STG]) begin
      ob_r <= bd_r[Q_W-1];
      ox_r <= xd_r[Q_W-1];
      oy_r <= yd_r[Q_W-1];
      for (int l = 0; l < N_LANE; l++) begin
        if (zd_r[Q_W-1]) begin
          oc_r[l] <= '0;
        end else if (q[l] > Q_W'(255)) begin
          oc_r[l] <= 8'd255;
        end else begin
          oc_r[l] <= q[l][7:0];
        end
      end
    end
  end

  assign out_rsp.valid     = v_r[OUT_STG];
  assign out_rsp.in_bounds = ob_r;
  assign out_rsp.out_x     = ox_r;
  assign out_rsp.out_y     = oy_r;
  assign out_rsp.out_red   = oc_r[0];
  assign out_rsp.out_green = oc_r[1];
  assign out_rsp.out_blue  = oc_r[2];
  assign out_rsp.out_alpha = oc_r[3];

  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && !out_rsp.in_bounds) |->
      (out_rsp.out_x == '0 && out_rsp.out_y == '0 && out_rsp.out_alpha == '0))
    else $error("clipped result carries nonzero fields");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(v_r[0]) && v_r[0]) |-> $past(in_req.valid && in_req.ready))
    else $error("stage 1 valid without accepted request");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (v_r == '0))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

/* tb/tb_rgba8_source_over_blend.sv */
// ----------------------------------------------------------------------------
// tb_rgba8_source_over_blend
// Self-checking bench for the source-over blend pipeline: a directed table,
// then random pixel requests under several register settings, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_rgba8_source_over_blend;
  import sob_pkg::*;

  localparam int CB = 14;
  localparam int IDLE_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 112;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [7:0]    sr, sg, sb, sa;
    logic [7:0]    dr, dg, db, da;
  } pix_req_t;

  typedef struct packed {
    logic          inb;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [7:0]    r, g, b, a;
  } pix_rsp_t;

  typedef struct {
    bit       at_reset;
    bit       typed;
    pix_req_t req;
    pix_rsp_t rsp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sob_in_if  #(.COORD_BITS(CB)) in_req();
  sob_out_if #(.COORD_BITS(CB)) out_rsp();

  rgba8_source_over_blend #(.COORD_BITS(CB)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the block's registers
  logic [16:0]        opacity;
  logic signed [15:0] shift_x, shift_y;
  logic [14:0]        width, height;

  pix_rsp_t pending_px[$];
  dir_row_t dir_rows[$];
  int  n_err, n_mismatch, n_sent, n_inb, n_done, n_cfg;
  bit  calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 600000);
    $display("timeout: %0d results still expected", pending_px.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] div_round(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (2 * num + den) / (2 * den);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic pix_rsp_t blend_pixel(pix_req_t q);
    pix_rsp_t o;
    longint dx, dy, w, h;
    longint unsigned op, s, inv, oa, full_d;
    full_d = 64'd255 * 64'd65536;
    o = '0;
    dx = longint'(q.x) + longint'(shift_x);
    dy = longint'(q.y) + longint'(shift_y);
    w = (width > 15'd16384) ? 16384 : longint'(width);
    h = (height > 15'd16384) ? 16384 : longint'(height);
    if (dx < 0 || dy < 0 || dx >= w || dy >= h) return o;
    o.inb = 1'b1;
    o.x = dx[CB-1:0];
    o.y = dy[CB-1:0];
    op = (opacity > 17'd65536) ? 65536 : longint'(opacity);
    s = longint'(q.sa) * op;
    inv = full_d - s;
    oa = 255 * s + longint'(q.da) * inv;
    if (oa == 0) return o;
    o.r = div_round(q.sr * 255 * s + longint'(q.dr) * q.da * inv, oa);
    o.g = div_round(q.sg * 255 * s + longint'(q.dg) * q.da * inv, oa);
    o.b = div_round(q.sb * 255 * s + longint'(q.db) * q.da * inv, oa);
    o.a = div_round(oa, full_d);
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 30) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // aim many coordinates at the clip edges of the destination
  function automatic logic [CB-1:0] pick_coord(logic signed [15:0] sh, logic [14:0] sz);
    int r, lim, t;
    r = $urandom_range(0, 99);
    lim = (sz > 15'd16384) ? 16384 : int'(sz);
    if (r < 55) begin
      if ($urandom_range(0, 1)) t = $urandom_range(0, 2) - 1;
      else t = lim + $urandom_range(0, 2) - 2;
      if ($urandom_range(0, 3) == 0) t = $urandom_range(0, lim);
      t = t - int'(sh);
      if (t >= 0 && t < (1 << CB)) return t[CB-1:0];
    end
    if (r < 65) return $urandom_range(0, 1) ? '1 : '0;
    return CB'($urandom_range(0, (1 << CB) - 1));
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_OPACITY: opacity = data[16:0];
      REG_SHIFT_X: shift_x = data[15:0];
      REG_SHIFT_Y: shift_y = data[15:0];
      REG_DEST_W:  width = data[14:0];
      REG_DEST_H:  height = data[14:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_config(logic [16:0] op, logic [15:0] sx, logic [15:0] sy,
                            logic [14:0] w, logic [14:0] h);
    cfg_write(REG_OPACITY, op);
    cfg_write(REG_SHIFT_X, {1'($urandom_range(0, 1)), sx});
    cfg_write(REG_SHIFT_Y, {1'($urandom_range(0, 1)), sy});
    cfg_write(REG_DEST_W, {2'($urandom_range(0, 3)), w});
    cfg_write(REG_DEST_H, {2'($urandom_range(0, 3)), h});
    cfg_write(CFG_IDX_W'($urandom_range(5, 7)),
              CFG_DATA_W'($urandom_range(0, (1 << 17) - 1)));
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_px.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_px(pix_req_t q, bit typed, pix_rsp_t e);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pending_px.push_back(typed ? e : blend_pixel(q));
    in_req.valid <= 1'b1;
    {in_req.src_x, in_req.src_y, in_req.src_red, in_req.src_green, in_req.src_blue,
     in_req.src_alpha, in_req.dst_red, in_req.dst_green, in_req.dst_blue,
     in_req.dst_alpha} <= q;
    do @(posedge clk); while (!in_req.ready);
    n_sent++;
  endtask

  task automatic random_phase(int n);
    pix_req_t q;
    repeat (n) begin
      q.x = pick_coord(shift_x, width);
      q.y = pick_coord(shift_y, height);
      q.sr = pick_byte(); q.sg = pick_byte(); q.sb = pick_byte(); q.sa = pick_byte();
      q.dr = pick_byte(); q.dg = pick_byte(); q.db = pick_byte(); q.da = pick_byte();
      send_px(q, 1'b0, '0);
    end
    in_req.valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    pix_rsp_t got, want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got = {out_rsp.in_bounds, out_rsp.out_x, out_rsp.out_y, out_rsp.out_red,
             out_rsp.out_green, out_rsp.out_blue, out_rsp.out_alpha};
      if (pending_px.size() == 0) begin
        n_err++;
        $display("unexpected result inb=%0d x=%0d y=%0d", got.inb, got.x, got.y);
      end else begin
        want = pending_px.pop_front();
        n_done++;
        if (got.inb) n_inb++;
        if (got.inb !== want.inb || got.x !== want.x || got.y !== want.y ||
            got.r !== want.r || got.g !== want.g || got.b !== want.b ||
            got.a !== want.a) begin
          n_err++;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch #%0d exp inb=%0d x=%0d y=%0d rgba=%0d,%0d,%0d,%0d act inb=%0d x=%0d y=%0d rgba=%0d,%0d,%0d,%0d",
                     n_done, want.inb, want.x, want.y, want.r, want.g, want.b, want.a,
                     got.inb, got.x, got.y, got.r, got.g, got.b, got.a);
        end
      end
    end
  end

  // result-side stalls
  initial begin
    int g;
    out_rsp.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic dir_row_t row(bit rs, bit ty, pix_req_t q, pix_rsp_t e);
    dir_row_t d;
    d.at_reset = rs;
    d.typed = ty;
    d.req = q;
    d.rsp = e;
    return d;
  endfunction

  initial begin
    bit cfg_done;
    n_err = 0; n_mismatch = 0; n_sent = 0; n_inb = 0; n_done = 0; n_cfg = 0;
    calm = 1'b0;
    cfg_done = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    in_req.valid <= 1'b0;
    {in_req.src_x, in_req.src_y, in_req.src_red, in_req.src_green, in_req.src_blue,
     in_req.src_alpha, in_req.dst_red, in_req.dst_green, in_req.dst_blue,
     in_req.dst_alpha} <= '0;
    opacity = 17'd65536; shift_x = '0; shift_y = '0; width = '0; height = '0;

    // reset state: empty destination clips everything
    dir_rows.push_back(row(1, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, '0));
    dir_rows.push_back(row(1, 1, '{16383, 16383, 255, 255, 255, 255, 255, 255, 255, 255},
                           '0));
    // opaque source copies through, transparent over transparent is zero, transparent source keeps the destination
    dir_rows.push_back(row(0, 1, '{0, 0, 255, 255, 255, 255, 0, 0, 0, 0},
                           '{1, 0, 0, 255, 255, 255, 255}));
    dir_rows.push_back(row(0, 1, '{16383, 16383, 12, 34, 56, 255, 200, 201, 202, 203},
                           '{1, 16383, 16383, 12, 34, 56, 255}));
    dir_rows.push_back(row(0, 1, '{1, 2, 255, 255, 255, 0, 255, 255, 255, 0},
                           '{1, 1, 2, 0, 0, 0, 0}));
    dir_rows.push_back(row(0, 1, '{5, 6, 77, 88, 99, 0, 9, 8, 7, 255},
                           '{1, 5, 6, 9, 8, 7, 255}));
    dir_rows.push_back(row(0, 0, '{3, 4, 255, 0, 128, 128, 0, 255, 64, 128}, '0));
    dir_rows.push_back(row(0, 0, '{10, 20, 255, 255, 255, 1, 0, 0, 0, 1}, '0));
    dir_rows.push_back(row(0, 0, '{11, 21, 0, 128, 255, 254, 255, 128, 0, 255}, '0));
    dir_rows.push_back(row(0, 0, '{12, 22, 100, 150, 200, 128, 9, 9, 9, 0}, '0));
    dir_rows.push_back(row(0, 0, '{8191, 4096, 1, 2, 3, 255, 4, 5, 6, 0}, '0));
    dir_rows.push_back(row(0, 0, '{9999, 1234, 255, 255, 255, 255, 255, 255, 255, 255}, '0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (!dir_rows[i].at_reset && !cfg_done) begin
        in_req.valid <= 1'b0;
        wait_drained();
        set_config(17'd65536, 16'd0, 16'd0, 15'd16384, 15'd16384);
        cfg_done = 1'b1;
      end
      send_px(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    end

    random_phase(ITEMS_PER_PHASE);
    wait_drained();
    set_config(17'd0, -16'sd5, 16'sd7, 15'd200, 15'd100);
    calm = 1'b1;
    random_phase(ITEMS_PER_PHASE);
    calm = 1'b0;
    wait_drained();
    set_config(17'h1FFFF, 16'sd32767, -16'sd32768, 15'd32767, 15'd32767);
    random_phase(ITEMS_PER_PHASE / 2);
    wait_drained();
    set_config(17'd32768, -16'sd16000, 16'sd16000, 15'd32767, 15'd32767);
    random_phase(ITEMS_PER_PHASE);
    wait_drained();
    set_config(17'd1, 16'sd100, -16'sd100, 15'd1, 15'd1);
    random_phase(ITEMS_PER_PHASE / 2);
    wait_drained();
    set_config(17'd65535, 16'sd3, 16'sd3, 15'd16385, 15'd50);
    random_phase(ITEMS_PER_PHASE);
    repeat (2) begin
      wait_drained();
      set_config(17'($urandom_range(0, 65536)), 16'($urandom_range(0, 65535) % 512 - 256),
                 16'($urandom_range(0, 511) - 256), 15'($urandom_range(1, 600)),
                 15'($urandom_range(1, 600)));
      random_phase(ITEMS_PER_PHASE);
    end

    while (pending_px.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    if (pending_px.size() != 0) n_err++;

    $display("sent %0d pixel requests over %0d register writes; %0d results, %0d in bounds",
             n_sent, n_cfg, n_done, n_inb);
    $display("errors: %0d (mismatches %0d)", n_err, n_mismatch);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sob_pkg.sv
rtl/sob_if.sv
rtl/sob_div.sv
rtl/rgba8_source_over_blend.sv
tb/tb_rgba8_source_over_blend.sv
